// File: hw/rtl/adjm_pkg.sv
// ----------------------------------------------------------------------------
// adjm_pkg
// Shared widths, opcodes and controller/datapath command and status types
// for the adjacency matrix graph store.
// ----------------------------------------------------------------------------
package adjm_pkg;

   localparam int unsigned OPCODE_W   = 3;
   localparam int unsigned VERTEX_W   = 4;
   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned VCOUNT_W   = 5;
   localparam int unsigned MAX_RESULTS = 16;
   localparam int unsigned COUNT_W    = $clog2(MAX_RESULTS + 1);
   localparam int unsigned UNIT_WEIGHT = 1;

   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

   typedef logic [OPCODE_W-1:0] opcode_type;

   localparam opcode_type OP_GET    = 3'd0;
   localparam opcode_type OP_SET    = 3'd1;
   localparam opcode_type OP_ADD    = 3'd2;
   localparam opcode_type OP_REMOVE = 3'd3;
   localparam opcode_type OP_FIRST  = 3'd4;
   localparam opcode_type OP_NEXT   = 3'd5;
   localparam opcode_type OP_LIST   = 3'd6;

   typedef logic [1:0] emit_sel_type;

   localparam emit_sel_type EMIT_ZERO = 2'd0;
   localparam emit_sel_type EMIT_GET  = 2'd1;
   localparam emit_sel_type EMIT_COL  = 2'd2;
   localparam emit_sel_type EMIT_HELD = 2'd3;

   typedef struct packed {
      logic         clear;
      logic         load;
      logic         advance;
      logic         capture;
      logic         write_cell;
      logic         emit;
      emit_sel_type emit_sel;
      logic         emit_last;
   } cmd_type;

   typedef struct packed {
      opcode_type req_op;
      logic       req_xin;
      logic       req_yin;
      opcode_type op;
      logic       out_free;
      logic       at_end;
      logic       nonzero;
      logic       held_valid;
      logic       cap_hit;
      logic       clear_done;
   } status_type;

endpackage

// File: hw/rtl/adjm_req_if.sv
// ----------------------------------------------------------------------------
// adjm_req_if
// Request channel: one opcode word with its vertices and weight.
// ----------------------------------------------------------------------------
interface adjm_req_if;

   logic                                    valid;
   logic                                    ready;
   logic [adjm_pkg::OPCODE_W-1:0]           opcode;
   logic [adjm_pkg::VERTEX_W-1:0]           src_vertex;
   logic [adjm_pkg::VERTEX_W-1:0]           dst_vertex;
   logic signed [adjm_pkg::VALUE_W-1:0]     weight;

   modport source (output valid, output opcode, output src_vertex, output dst_vertex,
                   output weight, input ready);
   modport sink   (input valid, input opcode, input src_vertex, input dst_vertex,
                   input weight, output ready);

endinterface

// File: hw/rtl/adjm_rsp_if.sv
// ----------------------------------------------------------------------------
// adjm_rsp_if
// Response channel: edge value, found flag, neighbor and last marker.
// ----------------------------------------------------------------------------
interface adjm_rsp_if;

   logic                                    valid;
   logic                                    ready;
   logic signed [adjm_pkg::VALUE_W-1:0]     edge_value;
   logic                                    found;
   logic [adjm_pkg::VERTEX_W-1:0]           neighbor;
   logic                                    last;

   modport source (output valid, output edge_value, output found, output neighbor,
                   output last, input ready);
   modport sink   (input valid, input edge_value, input found, input neighbor,
                   input last, output ready);

endinterface

// File: hw/rtl/adjacency_matrix_graph_store.sv
// ----------------------------------------------------------------------------
// adjacency_matrix_graph_store
// Directed weighted adjacency matrix with get/set/add/remove and neighbor scans.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one opcode word (opcode, src_vertex, dst_vertex, weight),
//   rsp_ch returns result words (edge_value, found, neighbor, last), both with
//   valid/ready. csr_we/csr_wdata write vertex_count; the user must do so
//   only while the block is idle, which the block leaves unchecked. After reset
//   the matrix RAM is swept to zero, one entry per cycle, over all MAX_VERTICES*MAX_VERTICES
//   entries (256 by default); req_ch.ready stays low meanwhile; vertex_count returns to 16.
//   One word is worked on at a time. Get/set/add/remove load the result
//   register once it is free; first/next neighbor scan the row up to the
//   first neighbor, or give a not-found word if none; a list scans the
//   row once, one column per cycle, giving one word per neighbor with last on
//   the final one (at most 16), or a single not-found word. The single read
//   port of the matrix RAM sets the one column per cycle scan rate.
//   A finished word sits in the output register; ready returns as soon as
//   the controller is idle, so a new request is taken while rsp_ch stalls.
//   A stalled receiver holds the scan in place until the word is taken.
// ----------------------------------------------------------------------------
module adjacency_matrix_graph_store #(
   parameter int unsigned MAX_VERTICES = 16,
   parameter int unsigned WEIGHT_BITS  = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   adjm_req_if.sink                        req_ch,
   adjm_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [adjm_pkg::VCOUNT_W-1:0]   csr_wdata
);

   adjm_pkg::cmd_type    cmd;
   adjm_pkg::status_type status;
   logic                 ctrl_ready;

   adjm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctrl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   adjm_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_opcode     (req_ch.opcode),
      .req_src_vertex (req_ch.src_vertex),
      .req_dst_vertex (req_ch.dst_vertex),
      .req_weight     (req_ch.weight),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_edge_value (rsp_ch.edge_value),
      .rsp_found      (rsp_ch.found),
      .rsp_neighbor   (rsp_ch.neighbor),
      .rsp_last       (rsp_ch.last)
   );

   assign req_ch.ready = ctrl_ready;

   // no request is taken while the matrix is being swept
   a_clear_blocks_req : assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_ch.ready)
      else $error("request accepted during clearing pass");

   // a word is only loaded into a free output register
   a_emit_needs_room : assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("response register overwritten");

   // neighbors are held back only for list requests
   a_capture_list_only : assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> (status.op == adjm_pkg::OP_LIST))
      else $error("neighbor captured outside a list scan");

   // a cell update always comes with its single answer
   a_write_with_emit : assert property (@(posedge clock) disable iff (reset)
      cmd.write_cell |-> (cmd.emit && cmd.emit_last))
      else $error("cell write without its response");

endmodule

// File: hw/rtl/adjm_ram.sv
// ----------------------------------------------------------------------------
// adjm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module adjm_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]           rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/adjm_dp.sv
// ----------------------------------------------------------------------------
// adjm_dp
// Datapath: request registers, row/column scan counter, matrix RAM,
// held neighbor for list results and the response output register.
// ----------------------------------------------------------------------------
module adjm_dp #(
   parameter int unsigned MAX_VERTICES = 16,
   parameter int unsigned WEIGHT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  adjm_pkg::cmd_type                    cmd,
   output adjm_pkg::status_type                 status,
   input  logic [adjm_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic [adjm_pkg::VERTEX_W-1:0]        req_src_vertex,
   input  logic [adjm_pkg::VERTEX_W-1:0]        req_dst_vertex,
   input  logic signed [adjm_pkg::VALUE_W-1:0]  req_weight,
   input  logic                                 csr_we,
   input  logic [adjm_pkg::VCOUNT_W-1:0]        csr_wdata,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [adjm_pkg::VALUE_W-1:0]  rsp_edge_value,
   output logic                                 rsp_found,
   output logic [adjm_pkg::VERTEX_W-1:0]        rsp_neighbor,
   output logic                                 rsp_last
);

   localparam int unsigned DEPTH    = MAX_VERTICES * MAX_VERTICES;
   localparam int unsigned AW       = $clog2(DEPTH);
   localparam int unsigned PW       = AW + 1;
   localparam int unsigned VW       = $clog2(MAX_VERTICES);
   localparam int unsigned CW       = $clog2(MAX_VERTICES + 1);
   localparam int unsigned NW       = (CW > adjm_pkg::VCOUNT_W) ? CW : adjm_pkg::VCOUNT_W;
   localparam int unsigned EXT_BITS = (WEIGHT_BITS > adjm_pkg::VALUE_W) ?
                                      WEIGHT_BITS : adjm_pkg::VALUE_W;

   logic [adjm_pkg::VCOUNT_W-1:0]  vcount_ff, vcount_in;
   adjm_pkg::opcode_type           op_ff, op_in;
   logic [VW-1:0]                  row_ff, row_in;
   logic [CW-1:0]                  col_ff, col_in;
   logic [WEIGHT_BITS-1:0]         weight_ff, weight_in;
   logic [VW-1:0]                  held_ff, held_in;
   logic                           held_valid_ff, held_valid_in;
   logic [adjm_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [AW-1:0]                  clr_ff, clr_in;
   logic [AW-1:0]                  addr_ff;
   logic [AW-1:0]                  rd_addr;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [adjm_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                           rsp_found_ff, rsp_found_in;
   logic [adjm_pkg::VERTEX_W-1:0]  rsp_nb_ff, rsp_nb_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic [NW-1:0]                  active_n;
   logic [adjm_pkg::VERTEX_W:0]    dst_plus;
   logic [adjm_pkg::VALUE_W-1:0]   req_weight_bits;
   logic [WEIGHT_BITS-1:0]         rd_data;
   logic signed [WEIGHT_BITS-1:0]  stored_s;
   logic signed [EXT_BITS-1:0]     stored_ext;
   logic                           nonzero;
   logic                           out_free;
   logic                           cell_we;
   logic [WEIGHT_BITS-1:0]         cell_wdata;
   logic                           ram_we;
   logic [AW-1:0]                  ram_waddr;
   logic [WEIGHT_BITS-1:0]         ram_wdata;

   // vertices in use, never more than the matrix holds
   assign active_n = (NW'(vcount_ff) < NW'(MAX_VERTICES)) ? NW'(vcount_ff) : NW'(MAX_VERTICES);

   assign dst_plus        = {1'b0, req_dst_vertex} + (adjm_pkg::VERTEX_W + 1)'(1);
   assign req_weight_bits = req_weight;
   assign nonzero         = |rd_data;
   assign out_free        = !rsp_valid_ff || rsp_ready;

   assign vcount_in = csr_we ? csr_wdata : vcount_ff;

   always_comb begin
      op_in         = op_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      weight_in     = weight_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      count_in      = count_ff;
      if (cmd.load) begin
         op_in         = req_opcode;
         row_in        = VW'(req_src_vertex);
         weight_in     = WEIGHT_BITS'(req_weight_bits);
         held_valid_in = 1'b0;
         count_in      = '0;
         case (req_opcode)
            adjm_pkg::OP_FIRST, adjm_pkg::OP_LIST: begin
               col_in = '0;
            end
            adjm_pkg::OP_NEXT: begin
               col_in = CW'(dst_plus);
            end
            default: begin
               col_in = CW'(req_dst_vertex);
            end
         endcase
      end else begin
         if (cmd.capture) begin
            held_in       = col_ff[VW-1:0];
            held_valid_in = 1'b1;
            count_in      = count_ff + adjm_pkg::COUNT_W'(1);
         end
         if (cmd.advance) begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // read address follows the next row/column so rd_data matches col_ff
   assign rd_addr = AW'(PW'(row_in) * PW'(MAX_VERTICES) + PW'(col_in[VW-1:0]));

   assign clr_in = cmd.clear ? clr_ff + AW'(1) : clr_ff;

   always_comb begin
      cell_we    = 1'b0;
      cell_wdata = '0;
      case (op_ff)
         adjm_pkg::OP_SET: begin
            cell_we    = cmd.write_cell;
            cell_wdata = weight_ff;
         end
         adjm_pkg::OP_ADD: begin
            cell_we    = cmd.write_cell && !nonzero;
            cell_wdata = WEIGHT_BITS'(adjm_pkg::UNIT_WEIGHT);
         end
         adjm_pkg::OP_REMOVE: begin
            cell_we    = cmd.write_cell && (rd_data == WEIGHT_BITS'(adjm_pkg::UNIT_WEIGHT));
            cell_wdata = '0;
         end
         default: begin
            cell_we    = 1'b0;
            cell_wdata = '0;
         end
      endcase
   end

   assign ram_we    = cmd.clear || cell_we;
   assign ram_waddr = cmd.clear ? clr_ff : addr_ff;
   assign ram_wdata = cmd.clear ? '0 : cell_wdata;

   adjm_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   // stored weight sign-extended from its own width, then cut to 16 bits
   assign stored_s   = rd_data;
   assign stored_ext = EXT_BITS'(stored_s);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      rsp_nb_in    = rsp_nb_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = cmd.emit_last;
         case (cmd.emit_sel)
            adjm_pkg::EMIT_GET: begin
               rsp_value_in = stored_ext[adjm_pkg::VALUE_W-1:0];
               rsp_found_in = nonzero;
               rsp_nb_in    = '0;
            end
            adjm_pkg::EMIT_COL: begin
               rsp_value_in = '0;
               rsp_found_in = 1'b1;
               rsp_nb_in    = adjm_pkg::VERTEX_W'(col_ff);
            end
            adjm_pkg::EMIT_HELD: begin
               rsp_value_in = '0;
               rsp_found_in = 1'b1;
               rsp_nb_in    = adjm_pkg::VERTEX_W'(held_ff);
            end
            default: begin
               rsp_value_in = '0;
               rsp_found_in = 1'b0;
               rsp_nb_in    = '0;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff     <= adjm_pkg::VCOUNT_RESET;
         clr_ff        <= '0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         vcount_ff     <= vcount_in;
         clr_ff        <= clr_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      weight_ff    <= weight_in;
      held_ff      <= held_in;
      count_ff     <= count_in;
      addr_ff      <= rd_addr;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
      rsp_nb_ff    <= rsp_nb_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_comb begin
      status.req_op     = req_opcode;
      status.req_xin    = NW'(req_src_vertex) < active_n;
      status.req_yin    = NW'(req_dst_vertex) < active_n;
      status.op         = op_ff;
      status.out_free   = out_free;
      status.at_end     = NW'(col_ff) >= active_n;
      status.nonzero    = nonzero;
      status.held_valid = held_valid_ff;
      status.cap_hit    = count_ff == adjm_pkg::COUNT_W'(adjm_pkg::MAX_RESULTS - 1);
      status.clear_done = clr_ff == AW'(DEPTH - 1);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_neighbor   = rsp_nb_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// File: hw/rtl/adjm_ctrl.sv
// ----------------------------------------------------------------------------
// adjm_ctrl
// Controller: clearing pass after reset, request dispatch, cell access,
// row scan and response sequencing.
// ----------------------------------------------------------------------------
module adjm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  adjm_pkg::status_type  status,
   output adjm_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ZERO   = 3'd2;
   localparam logic [2:0] ST_CELL   = 3'd3;
   localparam logic [2:0] ST_SCAN   = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       is_list;

   assign req_ready = (state_ff == ST_IDLE);
   assign is_list   = (status.op == adjm_pkg::OP_LIST);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (status.req_op)
                  adjm_pkg::OP_GET, adjm_pkg::OP_SET,
                  adjm_pkg::OP_ADD, adjm_pkg::OP_REMOVE: begin
                     state_in = (status.req_xin && status.req_yin) ? ST_CELL : ST_ZERO;
                  end
                  adjm_pkg::OP_FIRST, adjm_pkg::OP_LIST: begin
                     state_in = status.req_xin ? ST_SCAN : ST_ZERO;
                  end
                  adjm_pkg::OP_NEXT: begin
                     state_in = (status.req_xin && status.req_yin) ? ST_SCAN : ST_ZERO;
                  end
                  default: begin
                     state_in = ST_ZERO;
                  end
               endcase
            end
         end
         ST_ZERO: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = adjm_pkg::EMIT_ZERO;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_CELL: begin
            // write and answer in the same cycle so the write happens once
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_sel   = (status.op == adjm_pkg::OP_GET) ?
                                adjm_pkg::EMIT_GET : adjm_pkg::EMIT_ZERO;
               cmd.emit_last  = 1'b1;
               cmd.write_cell = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.at_end) begin
               state_in = is_list ? ST_FINISH : ST_ZERO;
            end else if (status.nonzero) begin
               if (!is_list) begin
                  if (status.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_sel  = adjm_pkg::EMIT_COL;
                     cmd.emit_last = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else if (!status.held_valid || status.out_free) begin
                  // previous neighbor goes out once a later one is known
                  cmd.emit      = status.held_valid;
                  cmd.emit_sel  = adjm_pkg::EMIT_HELD;
                  cmd.emit_last = 1'b0;
                  cmd.capture   = 1'b1;
                  if (status.cap_hit) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.advance = 1'b1;
                  end
               end
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_sel  = status.held_valid ? adjm_pkg::EMIT_HELD : adjm_pkg::EMIT_ZERO;
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
